// ===== rtl/aisc_pkg.sv =====
`default_nettype none
package aisc_pkg;
  localparam int unsigned DataW = 32;
  localparam int unsigned FractionBitsDef = 16;
  localparam int unsigned ModeW = 3;
  localparam int unsigned RawSelW = 2;
  localparam int unsigned AddrW = 5;

  typedef enum logic [ModeW-1:0] {
    MODE_SIG_LIN  = 3'd0,
    MODE_SEN_LIN  = 3'd1,
    MODE_QUAD     = 3'd2,
    MODE_ROOT_CLP = 3'd3,
    MODE_ROOT_SGN = 3'd4
  } mode_t;

  typedef enum logic [RawSelW-1:0] {
    RAW_W8  = 2'd0,
    RAW_W16 = 2'd1,
    RAW_W32 = 2'd2
  } raw_sel_t;

  typedef enum logic [2:0] {
    REG_SIG_OFF  = 3'd0,
    REG_SIG_GAIN = 3'd1,
    REG_C0       = 3'd2,
    REG_C1       = 3'd3,
    REG_C2       = 3'd4,
    REG_MODE     = 3'd5,
    REG_SIGNED   = 3'd6,
    REG_WIDTH    = 3'd7
  } reg_idx_t;

  // saturate a 72-bit signed value to 32 bits
  function automatic logic [32:0] sat32(input logic signed [71:0] v);
    logic [32:0] r;
    if (v > 72'sh7FFFFFFF) r = {1'b1, 32'h7FFF_FFFF};
    else if (v < -72'sh80000000) r = {1'b1, 32'h8000_0000};
    else r = {1'b0, v[31:0]};
    return r;
  endfunction
endpackage
`default_nettype wire

// ===== rtl/aisc_if.sv =====
`default_nettype none
interface aisc_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] raw_sample;
  modport source(output valid, output raw_sample, input ready);
  modport sink(input valid, input raw_sample, output ready);
endinterface

interface aisc_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] physical_value;
  logic               saturated;
  logic               mode_error;
  modport source(output valid, output physical_value, output saturated,
                 output mode_error, input ready);
  modport sink(input valid, input physical_value, input saturated,
               input mode_error, output ready);
endinterface
`default_nettype wire

// ===== rtl/aisc_sqrt.sv =====
`default_nettype none
// pipelined integer square root, one result bit per stage
module aisc_sqrt #(
  parameter int unsigned RadW = 48
) (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic [RadW-1:0]   radicand,
  output logic      [RadW/2-1:0] root
);
  localparam int unsigned NStg = RadW / 2;

  logic [RadW-1:0] rem_tap [NStg+1];
  logic [NStg-1:0] res_tap [NStg+1];

  assign rem_tap[0] = radicand;
  assign res_tap[0] = '0;

  // each stage decides one root bit from the top down
  for (genvar g = 0; g < NStg; g++) begin : g_stg
    localparam int unsigned B = NStg - 1 - g;
    logic [RadW-1:0] trial;
    logic [RadW-1:0] rem_r;
    logic [NStg-1:0] res_r;
    assign trial = (RadW'(res_tap[g]) << (B + 1)) | (RadW'(1) << (2 * B));
    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_tap[g] >= trial) begin
          rem_r <= rem_tap[g] - trial;
          res_r <= res_tap[g] | (NStg'(1) << B);
        end else begin
          rem_r <= rem_tap[g];
          res_r <= res_tap[g];
        end
      end
    end
    assign rem_tap[g+1] = rem_r;
    assign res_tap[g+1] = res_r;
  end

  assign root = res_tap[NStg];
endmodule
`default_nettype wire

// ===== rtl/analog_input_sensor_conversion.sv =====
`default_nettype none
// Analog input conversion. Each raw converter word becomes a saturated signed
// fixed-point value with FRACTION_BITS fraction bits. The datapath is a fully
// pipelined chain with no feedback: one transaction is taken per cycle unless the
// output stalls. With 16 fraction bits there are 31 register stages (raw count,
// linear product, linear sum, polynomial product, polynomial sum, a 24-stage square
// root, root product, output); the root takes (33 + FRACTION_BITS) / 2 stages in
// general. A stall on the result side halts the whole pipe; in_ready follows
// out_ready or an empty output stage.
module analog_input_sensor_conversion #(
  parameter int unsigned FRACTION_BITS = aisc_pkg::FractionBitsDef
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  aisc_in_if.sink                         in_ch,
  aisc_out_if.source                      out_ch,
  input  wire logic                       cfg_psel,
  input  wire logic                       cfg_penable,
  input  wire logic                       cfg_pwrite,
  input  wire logic [aisc_pkg::AddrW-1:0] cfg_paddr,
  input  wire logic [31:0]                cfg_pwdata,
  output logic      [31:0]                cfg_prdata,
  output logic                            cfg_pready
);
  import aisc_pkg::*;

  localparam int unsigned RadW = 32 + FRACTION_BITS + (FRACTION_BITS % 2);
  localparam int unsigned RootW = RadW / 2;
  localparam int unsigned NDly = RootW;
  localparam int unsigned NPipe = RootW + 7;
  localparam logic signed [71:0] Half = 72'sd1 <<< (FRACTION_BITS - 1);

  // configuration registers
  logic [31:0] off_r, gain_r, c0_r, c1_r, c2_r;
  logic [2:0]  mode_r;
  logic        sgn_r;
  logic [1:0]  wsel_r;
  logic        wr_en;
  reg_idx_t    widx;

  assign cfg_pready = 1'b1;
  assign widx  = reg_idx_t'(cfg_paddr[4:2]);
  assign wr_en = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r  <= '0;
      gain_r <= 32'd1 << FRACTION_BITS;
      c0_r   <= '0;
      c1_r   <= 32'd1 << FRACTION_BITS;
      c2_r   <= '0;
      mode_r <= MODE_SIG_LIN;
      sgn_r  <= 1'b0;
      wsel_r <= RAW_W16;
    end else if (wr_en) begin
      case (widx)
        REG_SIG_OFF:  off_r  <= cfg_pwdata;
        REG_SIG_GAIN: gain_r <= cfg_pwdata;
        REG_C0:       c0_r   <= cfg_pwdata;
        REG_C1:       c1_r   <= cfg_pwdata;
        REG_C2:       c2_r   <= cfg_pwdata;
        REG_MODE:     mode_r <= cfg_pwdata[2:0];
        REG_SIGNED:   sgn_r  <= cfg_pwdata[0];
        REG_WIDTH:    wsel_r <= cfg_pwdata[1:0];
        default:      ;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (widx)
      REG_SIG_OFF:  cfg_prdata = off_r;
      REG_SIG_GAIN: cfg_prdata = gain_r;
      REG_C0:       cfg_prdata = c0_r;
      REG_C1:       cfg_prdata = c1_r;
      REG_C2:       cfg_prdata = c2_r;
      REG_MODE:     cfg_prdata = {29'd0, mode_r};
      REG_SIGNED:   cfg_prdata = {31'd0, sgn_r};
      REG_WIDTH:    cfg_prdata = {30'd0, wsel_r};
      default:      cfg_prdata = '0;
    endcase
  end

  // pipeline advance and valid chain
  logic             adv;
  logic [NPipe-1:0] vld_r;
  assign adv = !vld_r[NPipe-1] || out_ch.ready;
  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (adv) vld_r <= {vld_r[NPipe-2:0], in_ch.valid};
  end

  // stage 1: raw count
  logic signed [32:0] cnt;
  logic signed [32:0] cnt_r;
  always_comb begin
    case (wsel_r)
      RAW_W8:  cnt = sgn_r ? 33'(signed'(in_ch.raw_sample[7:0]))
                           : {25'd0, in_ch.raw_sample[7:0]};
      RAW_W16: cnt = sgn_r ? 33'(signed'(in_ch.raw_sample[15:0]))
                           : {17'd0, in_ch.raw_sample[15:0]};
      default: cnt = sgn_r ? 33'(signed'(in_ch.raw_sample))
                           : {1'b0, in_ch.raw_sample};
    endcase
  end
  always_ff @(posedge clk) if (adv) cnt_r <= cnt;

  // stage 2: product gain*r (or c1*r)
  logic signed [71:0] p1_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      if (mode_r == MODE_SEN_LIN) p1_r <= 72'(signed'(c1_r)) * 72'(cnt_r);
      else                        p1_r <= 72'(signed'(gain_r)) * 72'(cnt_r);
    end
  end

  // stage 3: s = sat(offset + p) (or sat(c0 + p))
  logic [32:0] s_nxt;
  logic signed [31:0] s_r;
  logic sat3_r;
  always_comb begin
    if (mode_r == MODE_SEN_LIN) s_nxt = sat32(72'(signed'(c0_r)) + p1_r);
    else                        s_nxt = sat32(72'(signed'(off_r)) + p1_r);
  end
  always_ff @(posedge clk) if (adv) begin
    s_r <= s_nxt[31:0];
    sat3_r <= s_nxt[32];
  end

  // stage 4: product c2*s (quadratic) or c1*s (root)
  logic signed [71:0] p2_r;
  logic signed [31:0] s4_r;
  logic sat4_r;
  always_ff @(posedge clk) if (adv) begin
    if (mode_r == MODE_QUAD) p2_r <= 72'(signed'(c2_r)) * 72'(s_r);
    else                     p2_r <= 72'(signed'(c1_r)) * 72'(s_r);
    s4_r   <= s_r;
    sat4_r <= sat3_r;
  end

  // stage 5: t = sat(c1 + rnd(c2*s)) or a = sat(c0 + rnd(c1*s))
  // the linear modes keep only the flag of the linear sum
  logic signed [71:0] rnd2;
  logic [32:0] t_nxt;
  logic signed [31:0] t_r, s5_r;
  logic sat5_r;
  always_comb begin
    rnd2 = (p2_r + Half) >>> FRACTION_BITS;
    if (mode_r == MODE_QUAD) t_nxt = sat32(72'(signed'(c1_r)) + rnd2);
    else                     t_nxt = sat32(72'(signed'(c0_r)) + rnd2);
  end
  always_ff @(posedge clk) if (adv) begin
    t_r <= t_nxt[31:0];
    s5_r <= s4_r;
    sat5_r <= sat4_r |
              (t_nxt[32] & (mode_r inside {MODE_QUAD, MODE_ROOT_CLP, MODE_ROOT_SGN}));
  end

  // stage 6: quadratic product t*s, root radicand |a| << F
  logic signed [71:0] p3_r;
  logic [RadW-1:0] rad;
  logic [31:0] mag;
  assign mag = t_r[31] ? 32'(-t_r) : t_r;
  assign rad = RadW'(mag) << FRACTION_BITS;
  always_ff @(posedge clk) if (adv) p3_r <= 72'(signed'(t_r)) * 72'(s5_r);

  logic [RootW-1:0] root;
  aisc_sqrt #(.RadW(RadW)) u_sqrt (.clk(clk), .en(adv), .radicand(rad), .root(root));

  // delay lines alongside the root pipe
  logic        neg_dly_r [NDly];
  logic        sat_dly_r [NDly];
  logic [71:0] p3_dly_r  [NDly-1];
  logic [31:0] s_dly_r   [NDly+1];
  always_ff @(posedge clk) if (adv) begin
    neg_dly_r[0] <= t_r[31];
    sat_dly_r[0] <= sat5_r;
    p3_dly_r[0]  <= p3_r;
    s_dly_r[0]   <= s5_r;
    for (int i = 1; i < NDly; i++) begin
      neg_dly_r[i] <= neg_dly_r[i-1];
      sat_dly_r[i] <= sat_dly_r[i-1];
    end
    for (int i = 1; i < NDly - 1; i++) p3_dly_r[i] <= p3_dly_r[i-1];
    for (int i = 1; i < NDly + 1; i++) s_dly_r[i] <= s_dly_r[i-1];
  end

  // root product: c2*root, negated for a negative signed root
  logic signed [71:0] p4_r, p3f_r;
  logic neg7_r, sat7_r;
  always_ff @(posedge clk) if (adv) begin
    if (neg_dly_r[NDly-1]) p4_r <= -(72'(signed'(c2_r)) * 72'(signed'({1'b0, root})));
    else                   p4_r <= 72'(signed'(c2_r)) * 72'(signed'({1'b0, root}));
    p3f_r  <= p3_dly_r[NDly-2];
    neg7_r <= neg_dly_r[NDly-1];
    sat7_r <= sat_dly_r[NDly-1];
  end

  // final stage: rounding, saturation and mode selection
  logic signed [71:0] rq, rr;
  logic [32:0] yq, yr;
  logic [31:0] y_nxt;
  logic ys_nxt, err_nxt;
  always_comb begin
    rq = (p3f_r + Half) >>> FRACTION_BITS;
    rr = (p4_r + Half) >>> FRACTION_BITS;
    yq = sat32(72'(signed'(c0_r)) + rq);
    yr = sat32(rr);
    err_nxt = 1'b0;
    case (mode_r)
      MODE_SIG_LIN, MODE_SEN_LIN: begin
        y_nxt = s_dly_r[NDly];
        ys_nxt = sat7_r;
      end
      MODE_QUAD: begin
        y_nxt = yq[31:0];
        ys_nxt = sat7_r | yq[32];
      end
      MODE_ROOT_CLP: begin
        y_nxt = neg7_r ? 32'd0 : yr[31:0];
        ys_nxt = sat7_r | (!neg7_r & yr[32]);
      end
      MODE_ROOT_SGN: begin
        y_nxt = yr[31:0];
        ys_nxt = sat7_r | yr[32];
      end
      default: begin
        y_nxt = '0;
        ys_nxt = 1'b0;
        err_nxt = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) if (adv) begin
    out_ch.physical_value <= y_nxt;
    out_ch.saturated      <= ys_nxt;
    out_ch.mode_error     <= err_nxt;
  end
  assign out_ch.valid = vld_r[NPipe-1];

`ifndef SYNTHESIS
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.physical_value))
    else $error("result changed under stall");
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.mode_error |-> out_ch.physical_value == 32'd0 && !out_ch.saturated)
    else $error("mode error with nonzero value");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_ch.valid |-> in_ch.ready)
    else $error("input stalled with empty output");
`endif
endmodule
`default_nettype wire
